[design/chd_pkg.sv]
// ----------------------------------------------------------------------------
// chd_pkg: shared types and constants of the cosine hemisphere direction core
// Fixed-point format, unit sizes, stage alignment and rounding helpers.
// ----------------------------------------------------------------------------
package chd_pkg;

  // Q1.14 vectors
  localparam int FRAC_BITS = 14;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int HALF      = 1 << (FRAC_BITS - 1);
  // shift that turns a 16-bit random fraction into a Q.(2*FRAC_BITS) radicand
  localparam int RW_SH     = 2 * FRAC_BITS - 16;

  // root width of the elevation and normal square roots
  localparam int SQ_W  = FRAC_BITS + 1;
  // root width of the disk radius square root
  localparam int DR_W  = 17;
  // quotient widths of the angle and scale dividers
  localparam int CT_Q  = FRAC_BITS + 1;
  localparam int K_Q   = 2 * FRAC_BITS;
  // padding so the angle path lines up with the scale path
  localparam int D_LEN = (SQ_W + K_Q) - (DR_W + CT_Q);

  typedef logic signed [15:0] q14_t;

  // words riding beside the radius square root
  typedef struct packed {
    logic        valid;
    logic        u_neg;
    logic        v_neg;
    logic [16:0] u_mag;
    logic [16:0] v_mag;
    q14_t        nx;
    q14_t        ny;
    q14_t        nz;
    logic        pole;
    logic        down;
    logic [14:0] mf;
  } front_t;

  // words riding beside the angle dividers
  typedef struct packed {
    logic        valid;
    logic        u_neg;
    logic        v_neg;
    q14_t        nx;
    q14_t        ny;
    q14_t        nz;
    logic        pole;
    logic        down;
    logic [14:0] mf;
  } mid_t;

  // words waiting for the scale divider
  typedef struct packed {
    logic        valid;
    q14_t        ct;
    q14_t        st;
    q14_t        nx;
    q14_t        ny;
    q14_t        nz;
    logic        pole;
    logic        down;
    logic [14:0] mf;
  } ang_t;

  // elevation sine and cosine
  typedef struct packed {
    logic [SQ_W-1:0] sp;
    logic [SQ_W-1:0] cp;
  } elev_t;

  // drop the fraction of a product, rounding half away from zero
  function automatic logic signed [35:0] rnd(input logic signed [51:0] p);
    logic [51:0] mag;
    logic [35:0] r;
    mag = p[51] ? 52'(-p) : 52'(p);
    r   = 36'((mag + 52'(HALF)) >> FRAC_BITS);
    return p[51] ? -$signed(r) : $signed(r);
  endfunction

  // clamp to the unit range of a Q1.14 field
  function automatic q14_t pack(input logic signed [37:0] v);
    q14_t r;
    if (v > 38'(ONE)) begin
      r = 16'(ONE);
    end else if (v < -38'(ONE)) begin
      r = -16'(ONE);
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

[design/chd_isqrt.sv]
// ----------------------------------------------------------------------------
// chd_isqrt: pipelined floor integer square root
// One root bit per stage, OUT_W stages, a new radicand every enabled cycle.
// ----------------------------------------------------------------------------
module chd_isqrt #(
  parameter int OUT_W = 15
) (
  input  logic               clk,
  input  logic               en,
  input  logic [2*OUT_W-1:0] radicand,
  output logic [OUT_W-1:0]   root
);

  logic [2*OUT_W-1:0] rad_q [OUT_W];
  logic [OUT_W+1:0]   rem_q [OUT_W];
  logic [OUT_W-1:0]   root_q [OUT_W];

  logic [2*OUT_W-1:0] rad_next [OUT_W];
  logic [OUT_W+1:0]   rem_next [OUT_W];
  logic [OUT_W-1:0]   root_next [OUT_W];

  // one restoring step per stage: bring down two bits, try root*4+1
  always_comb begin
    logic [2*OUT_W-1:0] src_rad;
    logic [OUT_W+1:0]   src_rem;
    logic [OUT_W-1:0]   src_root;
    logic [OUT_W+1:0]   acc;
    logic [OUT_W+1:0]   trial;
    for (int s = 0; s < OUT_W; s++) begin
      if (s == 0) begin
        src_rad  = radicand;
        src_rem  = '0;
        src_root = '0;
      end else begin
        src_rad  = rad_q[(s == 0) ? 0 : s-1];
        src_rem  = rem_q[(s == 0) ? 0 : s-1];
        src_root = root_q[(s == 0) ? 0 : s-1];
      end
      acc   = {src_rem[OUT_W-1:0], src_rad[2*OUT_W-1 -: 2]};
      trial = {src_root, 2'b01};
      if (acc >= trial) begin
        rem_next[s]  = acc - trial;
        root_next[s] = {src_root[OUT_W-2:0], 1'b1};
      end else begin
        rem_next[s]  = acc;
        root_next[s] = {src_root[OUT_W-2:0], 1'b0};
      end
      rad_next[s] = {src_rad[2*OUT_W-3:0], 2'b00};
    end
  end

  // advance all stages together
  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < OUT_W; s++) begin
        rad_q[s]  <= rad_next[s];
        rem_q[s]  <= rem_next[s];
        root_q[s] <= root_next[s];
      end
    end
  end

  assign root = root_q[OUT_W-1];

endmodule

[design/chd_div.sv]
// ----------------------------------------------------------------------------
// chd_div: pipelined unsigned restoring divider
// Q_W quotient bits, one per stage; needs num < den * 2**Q_W.
// ----------------------------------------------------------------------------
module chd_div #(
  parameter int N_W = 31,
  parameter int D_W = 17,
  parameter int Q_W = 15
) (
  input  logic           clk,
  input  logic           en,
  input  logic [N_W-1:0] num,
  input  logic [D_W-1:0] den,
  output logic [Q_W-1:0] quo
);

  logic [D_W-1:0] rem_q [Q_W];
  logic [Q_W-1:0] low_q [Q_W];
  logic [D_W-1:0] den_q [Q_W];
  logic [Q_W-1:0] quo_q [Q_W];

  logic [D_W-1:0] rem_next [Q_W];
  logic [Q_W-1:0] low_next [Q_W];
  logic [Q_W-1:0] quo_next [Q_W];

  // shift in one dividend bit, subtract the divisor where it fits
  always_comb begin
    logic [D_W-1:0] src_rem;
    logic [Q_W-1:0] src_low;
    logic [D_W-1:0] src_den;
    logic [Q_W-1:0] src_quo;
    logic [D_W:0]   acc;
    logic           hit;
    for (int s = 0; s < Q_W; s++) begin
      if (s == 0) begin
        src_rem = D_W'(num >> Q_W);
        src_low = num[Q_W-1:0];
        src_den = den;
        src_quo = '0;
      end else begin
        src_rem = rem_q[(s == 0) ? 0 : s-1];
        src_low = low_q[(s == 0) ? 0 : s-1];
        src_den = den_q[(s == 0) ? 0 : s-1];
        src_quo = quo_q[(s == 0) ? 0 : s-1];
      end
      acc = {src_rem, src_low[Q_W-1]};
      hit = (acc >= {1'b0, src_den});
      rem_next[s] = hit ? D_W'(acc - {1'b0, src_den}) : D_W'(acc);
      low_next[s] = {src_low[Q_W-2:0], 1'b0};
      quo_next[s] = {src_quo[Q_W-2:0], hit};
    end
  end

  // advance all stages together, divisor travels with its dividend
  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < Q_W; s++) begin
        rem_q[s] <= rem_next[s];
        low_q[s] <= low_next[s];
        quo_q[s] <= quo_next[s];
      end
      den_q[0] <= den;
      for (int s = 1; s < Q_W; s++) begin
        den_q[s] <= den_q[s-1];
      end
    end
  end

  assign quo = quo_q[Q_W-1];

endmodule

[design/cosine_hemisphere_direction_core.sv]
// ----------------------------------------------------------------------------
// cosine_hemisphere_direction_core: cosine-weighted reflection direction
// Maps a unit normal and three random fractions to a direction about it.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one word: normal_x/y/z in Q1.14
//   and the random fractions rand_u, rand_v, rand_w. Output channel
//   out_valid/out_ready carries dir_x/y/z in Q1.14. A word whose disk point
//   lands outside the unit disk or exactly on its center gives no output.
//   cfg_we/cfg_data write pole_threshold; write it only while idle.
//   One word enters per cycle while the pipeline advances. The long path is
//   the chain of bit-per-stage units: a 15-stage square root of 1 - nz^2
//   followed by a 28-stage divider for the frame scale, then six multiply
//   and round stages.
//   The whole pipeline advances when the output register is empty or taken,
//   so a stalled receiver holds every stage and in_ready drops with it;
//   nothing is lost or repeated.
//   Reset (synchronous, active high) clears all valid bits and sets
//   pole_threshold to 1.
// ----------------------------------------------------------------------------
module cosine_hemisphere_direction_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [14:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] normal_x,
  input  logic signed [15:0] normal_y,
  input  logic signed [15:0] normal_z,
  input  logic [15:0]        rand_u,
  input  logic [15:0]        rand_v,
  input  logic [15:0]        rand_w,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] dir_x,
  output logic signed [15:0] dir_y,
  output logic signed [15:0] dir_z
);

  localparam int SQ_W  = chd_pkg::SQ_W;
  localparam int DR_W  = chd_pkg::DR_W;
  localparam int CT_Q  = chd_pkg::CT_Q;
  localparam int K_Q   = chd_pkg::K_Q;
  localparam int D_LEN = chd_pkg::D_LEN;
  localparam int FB    = chd_pkg::FRAC_BITS;

  logic [14:0] eps;
  logic        adv;

  // hold the pole threshold
  always_ff @(posedge clk) begin
    if (rst) begin
      eps <= 15'd1;
    end else if (cfg_we) begin
      eps <= cfg_data;
    end
  end

  // advance everything when the output register can take a word
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // ---------------- stage 0: capture input word
  logic               s0_valid;
  chd_pkg::q14_t      s0_nx, s0_ny, s0_nz;
  logic [15:0]        s0_ru, s0_rv, s0_rw;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (adv) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_nx <= normal_x;
      s0_ny <= normal_y;
      s0_nz <= normal_z;
      s0_ru <= rand_u;
      s0_rv <= rand_v;
      s0_rw <= rand_w;
    end
  end

  // ---------------- stage 1: disk point and squares
  logic signed [17:0] u_c, v_c;
  logic signed [35:0] usq_c, vsq_c;
  logic signed [31:0] nzsq_c;

  assign u_c    = 18'sh10000 - $signed({1'b0, s0_ru, 1'b0});
  assign v_c    = 18'sh10000 - $signed({1'b0, s0_rv, 1'b0});
  assign usq_c  = u_c * u_c;
  assign vsq_c  = v_c * v_c;
  assign nzsq_c = s0_nz * s0_nz;

  logic               s1_valid;
  logic signed [17:0] s1_u, s1_v;
  logic [32:0]        s1_usq, s1_vsq;
  logic [30:0]        s1_nzsq;
  chd_pkg::q14_t      s1_nx, s1_ny, s1_nz;
  logic [15:0]        s1_rw;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_u    <= u_c;
      s1_v    <= v_c;
      s1_usq  <= usq_c[32:0];
      s1_vsq  <= vsq_c[32:0];
      s1_nzsq <= nzsq_c[30:0];
      s1_nx   <= s0_nx;
      s1_ny   <= s0_ny;
      s1_nz   <= s0_nz;
      s1_rw   <= s0_rw;
    end
  end

  // ---------------- stage 2: reject test, pole test, radicands
  logic [33:0]        d_c;
  logic               reject_c;
  logic signed [31:0] m_c;
  logic [16:0]        nz17_c, anz_c;
  logic               pole_c;
  chd_pkg::front_t    front_c;

  assign d_c      = {1'b0, s1_usq} + {1'b0, s1_vsq};
  assign reject_c = (d_c == '0) || (d_c > 34'h1_0000_0000);
  assign m_c      = $signed(32'(chd_pkg::ONE * chd_pkg::ONE)) - $signed({1'b0, s1_nzsq});
  assign nz17_c   = {s1_nz[15], s1_nz};
  assign anz_c    = s1_nz[15] ? 17'(-nz17_c) : nz17_c;
  assign pole_c   = ($signed({1'b0, anz_c}) > ($signed(18'(chd_pkg::ONE))
                    - $signed({3'b000, eps}))) || (m_c <= 0);

  always_comb begin
    front_c.valid = s1_valid && !reject_c;
    front_c.u_neg = s1_u[17];
    front_c.v_neg = s1_v[17];
    front_c.u_mag = s1_u[17] ? 17'(-s1_u) : s1_u[16:0];
    front_c.v_mag = s1_v[17] ? 17'(-s1_v) : s1_v[16:0];
    front_c.nx    = s1_nx;
    front_c.ny    = s1_ny;
    front_c.nz    = s1_nz;
    front_c.pole  = pole_c;
    front_c.down  = s1_nz[15] || (s1_nz == '0);
    front_c.mf    = 15'((30'(m_c[28:0]) + 30'(chd_pkg::HALF)) >> FB);
  end

  chd_pkg::front_t    s2_front;
  logic [2*DR_W-1:0]  s2_rad_d;
  logic [2*SQ_W-1:0]  s2_rad_q, s2_rad_sp, s2_rad_cp;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_front.valid <= 1'b0;
    end else if (adv) begin
      s2_front <= front_c;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_rad_d  <= (2*DR_W)'(d_c);
      s2_rad_q  <= pole_c ? '0 : (2*SQ_W)'(m_c[28:0]);
      s2_rad_sp <= (2*SQ_W)'({s1_rw, {chd_pkg::RW_SH{1'b0}}});
      s2_rad_cp <= (2*SQ_W)'({17'(17'h10000 - {1'b0, s1_rw}), {chd_pkg::RW_SH{1'b0}}});
    end
  end

  // ---------------- square root units
  logic [DR_W-1:0] s_root;
  logic [SQ_W-1:0] q_root, sp_root, cp_root;

  chd_isqrt #(.OUT_W(DR_W)) u_sqrt_d (
    .clk(clk), .en(adv), .radicand(s2_rad_d), .root(s_root)
  );
  chd_isqrt #(.OUT_W(SQ_W)) u_sqrt_q (
    .clk(clk), .en(adv), .radicand(s2_rad_q), .root(q_root)
  );
  chd_isqrt #(.OUT_W(SQ_W)) u_sqrt_sp (
    .clk(clk), .en(adv), .radicand(s2_rad_sp), .root(sp_root)
  );
  chd_isqrt #(.OUT_W(SQ_W)) u_sqrt_cp (
    .clk(clk), .en(adv), .radicand(s2_rad_cp), .root(cp_root)
  );

  // carry the word beside the radius root
  chd_pkg::front_t line_a [DR_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DR_W; i++) begin
        line_a[i].valid <= 1'b0;
      end
    end else if (adv) begin
      line_a[0] <= s2_front;
      for (int i = 1; i < DR_W; i++) begin
        line_a[i] <= line_a[i-1];
      end
    end
  end

  // ---------------- frame scale divider: k = sp / sqrt(1 - nz^2)
  logic [K_Q-1:0]  k_num;
  logic [SQ_W-1:0] k_den;
  logic [K_Q-1:0]  k_quo;

  assign k_num = K_Q'({sp_root[FB-1:0], {FB{1'b0}}}) + K_Q'(q_root >> 1);
  assign k_den = (q_root == '0) ? SQ_W'(1) : q_root;

  chd_div #(.N_W(K_Q), .D_W(SQ_W), .Q_W(K_Q)) u_div_k (
    .clk(clk), .en(adv), .num(k_num), .den(k_den), .quo(k_quo)
  );

  // hold sine and cosine of elevation until the scale is ready
  chd_pkg::elev_t line_b [K_Q];

  always_ff @(posedge clk) begin
    if (adv) begin
      line_b[0] <= '{sp: sp_root, cp: cp_root};
      for (int i = 1; i < K_Q; i++) begin
        line_b[i] <= line_b[i-1];
      end
    end
  end

  // ---------------- angle dividers: cT = u / |p|, sT = v / |p|
  chd_pkg::front_t a_out;
  logic [30:0]     ct_num, st_num;
  logic [CT_Q-1:0] ct_quo, st_quo;

  assign a_out  = line_a[DR_W-1];
  assign ct_num = 31'({a_out.u_mag, {FB{1'b0}}}) + 31'(s_root >> 1);
  assign st_num = 31'({a_out.v_mag, {FB{1'b0}}}) + 31'(s_root >> 1);

  chd_div #(.N_W(31), .D_W(DR_W), .Q_W(CT_Q)) u_div_ct (
    .clk(clk), .en(adv), .num(ct_num), .den(s_root), .quo(ct_quo)
  );
  chd_div #(.N_W(31), .D_W(DR_W), .Q_W(CT_Q)) u_div_st (
    .clk(clk), .en(adv), .num(st_num), .den(s_root), .quo(st_quo)
  );

  chd_pkg::mid_t line_c [CT_Q];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CT_Q; i++) begin
        line_c[i].valid <= 1'b0;
      end
    end else if (adv) begin
      line_c[0] <= '{valid: a_out.valid, u_neg: a_out.u_neg, v_neg: a_out.v_neg,
                     nx: a_out.nx, ny: a_out.ny, nz: a_out.nz, pole: a_out.pole,
                     down: a_out.down, mf: a_out.mf};
      for (int i = 1; i < CT_Q; i++) begin
        line_c[i] <= line_c[i-1];
      end
    end
  end

  // apply the angle signs, wait for the scale
  chd_pkg::mid_t c_out;
  chd_pkg::q14_t ct_c, st_c;
  chd_pkg::ang_t line_d [D_LEN];

  assign c_out = line_c[CT_Q-1];
  assign ct_c  = c_out.u_neg ? -$signed({1'b0, ct_quo}) : $signed({1'b0, ct_quo});
  assign st_c  = c_out.v_neg ? -$signed({1'b0, st_quo}) : $signed({1'b0, st_quo});

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < D_LEN; i++) begin
        line_d[i].valid <= 1'b0;
      end
    end else if (adv) begin
      line_d[0] <= '{valid: c_out.valid, ct: ct_c, st: st_c, nx: c_out.nx,
                     ny: c_out.ny, nz: c_out.nz, pole: c_out.pole,
                     down: c_out.down, mf: c_out.mf};
      for (int i = 1; i < D_LEN; i++) begin
        line_d[i] <= line_d[i-1];
      end
    end
  end

  chd_pkg::ang_t  d_out;
  chd_pkg::elev_t b_out;
  chd_pkg::q14_t  a_nx, a_ny, a_nz, a_ct, a_st;

  assign d_out = line_d[D_LEN-1];
  assign b_out = line_b[K_Q-1];
  assign a_nx  = d_out.nx;
  assign a_ny  = d_out.ny;
  assign a_nz  = d_out.nz;
  assign a_ct  = d_out.ct;
  assign a_st  = d_out.st;

  // ---------------- stage 46: first products
  logic               s46_valid, s46_pole, s46_down;
  logic signed [31:0] p_nxnz, p_nynz, p_nyst, p_nxst, p_mfct;
  logic signed [31:0] p_spct, p_spst, p_cpnx, p_cpny, p_cpnz;
  chd_pkg::q14_t      s46_ct;
  logic [K_Q-1:0]     s46_k;
  logic [SQ_W-1:0]    s46_cp;

  always_ff @(posedge clk) begin
    if (adv) begin
      p_nxnz  <= a_nx * a_nz;
      p_nynz  <= a_ny * a_nz;
      p_nyst  <= a_ny * a_st;
      p_nxst  <= a_nx * a_st;
      p_mfct  <= $signed({1'b0, d_out.mf}) * a_ct;
      p_spct  <= $signed({1'b0, b_out.sp}) * a_ct;
      p_spst  <= $signed({1'b0, b_out.sp}) * a_st;
      p_cpnx  <= $signed({1'b0, b_out.cp}) * a_nx;
      p_cpny  <= $signed({1'b0, b_out.cp}) * a_ny;
      p_cpnz  <= $signed({1'b0, b_out.cp}) * a_nz;
      s46_ct  <= a_ct;
      s46_k   <= k_quo;
      s46_cp  <= b_out.cp;
      s46_pole <= d_out.pole;
      s46_down <= d_out.down;
    end
  end

  // ---------------- stage 47: round first products
  logic               s47_valid, s47_pole, s47_down;
  logic signed [19:0] r_nxnz, r_nynz, r_nyst, r_nxst, r_mfct;
  logic signed [19:0] r_spct, r_spst, r_cpnx, r_cpny, r_cpnz;
  chd_pkg::q14_t      s47_ct;
  logic [K_Q-1:0]     s47_k;
  logic [SQ_W-1:0]    s47_cp;

  always_ff @(posedge clk) begin
    if (adv) begin
      r_nxnz   <= 20'(chd_pkg::rnd(52'(p_nxnz)));
      r_nynz   <= 20'(chd_pkg::rnd(52'(p_nynz)));
      r_nyst   <= 20'(chd_pkg::rnd(52'(p_nyst)));
      r_nxst   <= 20'(chd_pkg::rnd(52'(p_nxst)));
      r_mfct   <= 20'(chd_pkg::rnd(52'(p_mfct)));
      r_spct   <= 20'(chd_pkg::rnd(52'(p_spct)));
      r_spst   <= 20'(chd_pkg::rnd(52'(p_spst)));
      r_cpnx   <= 20'(chd_pkg::rnd(52'(p_cpnx)));
      r_cpny   <= 20'(chd_pkg::rnd(52'(p_cpny)));
      r_cpnz   <= 20'(chd_pkg::rnd(52'(p_cpnz)));
      s47_ct   <= s46_ct;
      s47_k    <= s46_k;
      s47_cp   <= s46_cp;
      s47_pole <= s46_pole;
      s47_down <= s46_down;
    end
  end

  // ---------------- stage 48: normal products times cT
  logic               s48_valid, s48_pole, s48_down;
  logic signed [35:0] m_nxnzct, m_nynzct;
  logic signed [19:0] s48_nyst, s48_nxst, s48_mfct, s48_spct, s48_spst;
  logic signed [19:0] s48_cpnx, s48_cpny, s48_cpnz;
  logic [K_Q-1:0]     s48_k;
  logic [SQ_W-1:0]    s48_cp;

  always_ff @(posedge clk) begin
    if (adv) begin
      m_nxnzct <= r_nxnz * s47_ct;
      m_nynzct <= r_nynz * s47_ct;
      s48_nyst <= r_nyst;
      s48_nxst <= r_nxst;
      s48_mfct <= r_mfct;
      s48_spct <= r_spct;
      s48_spst <= r_spst;
      s48_cpnx <= r_cpnx;
      s48_cpny <= r_cpny;
      s48_cpnz <= r_cpnz;
      s48_k    <= s47_k;
      s48_cp   <= s47_cp;
      s48_pole <= s47_pole;
      s48_down <= s47_down;
    end
  end

  // ---------------- stage 49: tangent terms
  logic               s49_valid, s49_pole, s49_down;
  logic signed [20:0] t1, t2;
  logic signed [19:0] s49_mfct, s49_spct, s49_spst, s49_cpnx, s49_cpny, s49_cpnz;
  logic [K_Q-1:0]     s49_k;
  logic [SQ_W-1:0]    s49_cp;

  always_ff @(posedge clk) begin
    if (adv) begin
      t1       <= 21'(s48_nyst) + 21'(chd_pkg::rnd(52'(m_nxnzct)));
      t2       <= 21'(s48_nxst) - 21'(chd_pkg::rnd(52'(m_nynzct)));
      s49_mfct <= s48_mfct;
      s49_spct <= s48_spct;
      s49_spst <= s48_spst;
      s49_cpnx <= s48_cpnx;
      s49_cpny <= s48_cpny;
      s49_cpnz <= s48_cpnz;
      s49_k    <= s48_k;
      s49_cp   <= s48_cp;
      s49_pole <= s48_pole;
      s49_down <= s48_down;
    end
  end

  // ---------------- stage 50: scale by k
  logic               s50_valid, s50_pole, s50_down;
  logic signed [51:0] t1k, t2k, mk;
  logic signed [19:0] s50_spct, s50_spst, s50_cpnx, s50_cpny, s50_cpnz;
  logic [SQ_W-1:0]    s50_cp;

  always_ff @(posedge clk) begin
    if (adv) begin
      t1k      <= t1 * $signed({1'b0, s49_k});
      t2k      <= t2 * $signed({1'b0, s49_k});
      mk       <= s49_mfct * $signed({1'b0, s49_k});
      s50_spct <= s49_spct;
      s50_spst <= s49_spst;
      s50_cpnx <= s49_cpnx;
      s50_cpny <= s49_cpny;
      s50_cpnz <= s49_cpnz;
      s50_cp   <= s49_cp;
      s50_pole <= s49_pole;
      s50_down <= s49_down;
    end
  end

  // valid bits of the product stages
  always_ff @(posedge clk) begin
    if (rst) begin
      s46_valid <= 1'b0;
      s47_valid <= 1'b0;
      s48_valid <= 1'b0;
      s49_valid <= 1'b0;
      s50_valid <= 1'b0;
    end else if (adv) begin
      s46_valid <= d_out.valid;
      s47_valid <= s46_valid;
      s48_valid <= s47_valid;
      s49_valid <= s48_valid;
      s50_valid <= s49_valid;
    end
  end

  // ---------------- stage 51: combine, pick frame, clamp
  logic signed [37:0] xr_c, yr_c, zr_c, xs_c, ys_c, zs_c;

  always_comb begin
    xr_c = 38'(s50_cpnx) - 38'(chd_pkg::rnd(t1k));
    yr_c = 38'(s50_cpny) + 38'(chd_pkg::rnd(t2k));
    zr_c = 38'(s50_cpnz) + 38'(chd_pkg::rnd(mk));
    if (s50_pole) begin
      xs_c = s50_down ? -38'(s50_spct) : 38'(s50_spct);
      ys_c = s50_down ? -38'(s50_spst) : 38'(s50_spst);
      zs_c = s50_down ? -38'($signed({1'b0, s50_cp})) : 38'($signed({1'b0, s50_cp}));
    end else begin
      xs_c = xr_c;
      ys_c = yr_c;
      zs_c = zr_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s50_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dir_x <= chd_pkg::pack(xs_c);
      dir_y <= chd_pkg::pack(ys_c);
      dir_z <= chd_pkg::pack(zs_c);
    end
  end

`ifndef ASSERT_OFF
  // a held result blocks the input side in the same cycle
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while output stalled");

  // every direction stays in the unit range
  a_dir_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (dir_x >= -16'sd16384 && dir_x <= 16'sd16384 &&
                   dir_y >= -16'sd16384 && dir_y <= 16'sd16384 &&
                   dir_z >= -16'sd16384 && dir_z <= 16'sd16384))
    else $error("direction component out of range");

  // the rotated frame is only used for a normal strictly off the poles
  a_frame_nz: assert property (@(posedge clk) disable iff (rst)
    d_out.valid && !d_out.pole |-> (a_nz > -16'sd16384 && a_nz < 16'sd16384))
    else $error("rotated frame chosen at a pole");

  // no result straight after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");
`endif

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for cosine_hemisphere_direction_core
// Drives normals and random fractions under random idling on both sides,
// predicts each direction (or its rejection) in fixed point, and compares
// every output word with the oldest prediction, across several thresholds.
// ----------------------------------------------------------------------------
module testbench;

  localparam longint QONE   = 64'sd1 << 14;
  localparam longint QHALF  = 64'sd1 << 13;
  localparam logic [63:0] SAT_LIM = 64'd1 << 62;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 60;

  typedef struct {
    chd_pkg::q14_t x;
    chd_pkg::q14_t y;
    chd_pkg::q14_t z;
  } dir_t;

  typedef struct {
    logic signed [15:0] nx, ny, nz;
    logic [15:0]        ru, rv, rw;
    bit                 typed;
    dir_t               want;
  } stim_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [14:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] normal_x = '0, normal_y = '0, normal_z = '0;
  logic [15:0] rand_u = '0, rand_v = '0, rand_w = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] dir_x, dir_y, dir_z;

  logic [14:0] threshold_model;
  dir_t        dir_queue[$];
  int          mismatches = 0;
  int          cycles = 0;
  bit          quiet = 1'b0;
  bit          took = 1'b0;
  int          stall_left = 0;

  cosine_hemisphere_direction_core u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
    .rand_u(rand_u), .rand_v(rand_v), .rand_w(rand_w),
    .out_valid(out_valid), .out_ready(out_ready),
    .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
    logic [63:0] res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] magnitude(input longint a);
    return a < 0 ? 64'(-a) : 64'(a);
  endfunction

  // Q.14 product, magnitude saturated, rounded half away from zero
  function automatic longint qmul(input longint a, input longint b);
    logic [63:0] ua, ub, p;
    longint r;
    ua = magnitude(a);
    ub = magnitude(b);
    if (ua != 0 && ub > SAT_LIM / ua) p = SAT_LIM;
    else p = ua * ub;
    if (p > SAT_LIM) p = SAT_LIM;
    r = longint'((p + 64'(QHALF)) >> 14);
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  function automatic longint qdiv(input longint num, input logic [63:0] den);
    logic [63:0] n;
    longint r;
    n = magnitude(num) << 14;
    r = longint'((n + den / 2) / den);
    return num < 0 ? -r : r;
  endfunction

  function automatic chd_pkg::q14_t clamp_unit(input longint v);
    if (v > QONE) v = QONE;
    if (v < -QONE) v = -QONE;
    return chd_pkg::q14_t'(v);
  endfunction

  // direction for one word; returns 0 when the disk point is rejected
  function automatic bit sample_direction(input stim_t s, output dir_t d);
    longint nx, ny, nz, u, v, ct, st, sp, cp, anz, m, k, mf, t1, t2, x, y, z;
    logic [63:0] rad2, rad, q;
    nx   = longint'(s.nx);
    ny   = longint'(s.ny);
    nz   = longint'(s.nz);
    u    = 65536 - 2 * longint'(s.ru);
    v    = 65536 - 2 * longint'(s.rv);
    rad2 = 64'(u * u) + 64'(v * v);
    d    = '{default: '0};
    if (rad2 == 0 || rad2 > (64'd1 << 32)) return 1'b0;
    rad = floor_sqrt(rad2);
    ct  = qdiv(u, rad);
    st  = qdiv(v, rad);
    sp  = longint'(floor_sqrt(64'(s.rw) << 12));
    cp  = longint'(floor_sqrt((64'd65536 - 64'(s.rw)) << 12));
    anz = nz < 0 ? -nz : nz;
    m   = QONE * QONE - nz * nz;
    if (anz > QONE - longint'(threshold_model) || m <= 0) begin
      x = qmul(sp, ct);
      y = qmul(sp, st);
      z = cp;
      if (nz <= 0) begin
        x = -x; y = -y; z = -z;
      end
    end else begin
      q = floor_sqrt(64'(m));
      if (q == 0) q = 1;
      k  = qdiv(sp, q);
      mf = longint'((64'(m) + 64'(QHALF)) >> 14);
      t1 = qmul(ny, st) + qmul(qmul(nx, nz), ct);
      t2 = qmul(nx, st) - qmul(qmul(ny, nz), ct);
      x  = qmul(cp, nx) - qmul(t1, k);
      y  = qmul(cp, ny) + qmul(t2, k);
      z  = qmul(cp, nz) + qmul(qmul(mf, ct), k);
    end
    d.x = clamp_unit(x);
    d.y = clamp_unit(y);
    d.z = clamp_unit(z);
    return 1'b1;
  endfunction

  // ------------------------------------------------------------------ driving
  task automatic send_word(input stim_t s);
    int gap;
    dir_t d;
    gap = quiet ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    normal_x <= s.nx;
    normal_y <= s.ny;
    normal_z <= s.nz;
    rand_u   <= s.ru;
    rand_v   <= s.rv;
    rand_w   <= s.rw;
    do @(posedge clk); while (!in_ready);
    if (sample_direction(s, d)) begin
      if (s.typed) d = s.want;
      dir_queue.push_back(d);
    end
    @(negedge clk);
  endtask

  // hold until every expected word is out, then let the pipe empty
  task automatic drain;
    in_valid <= 1'b0;
    while (dir_queue.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic write_threshold(input logic [14:0] val);
    cfg_we   <= 1'b1;
    cfg_data <= val;
    threshold_model = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic stim_t random_word(input int flavor);
    stim_t s;
    longint rest, lim;
    s.typed = 1'b0;
    s.want  = '{default: '0};
    s.ru = 16'($urandom);
    s.rv = 16'($urandom);
    s.rw = 16'($urandom);
    case (flavor)
      0: begin
        // any components within range
        s.nx = 16'($urandom_range(0, 32768) - 16384);
        s.ny = 16'($urandom_range(0, 32768) - 16384);
        s.nz = 16'($urandom_range(0, 32768) - 16384);
      end
      default: begin
        // near-unit normal, optionally hugging a pole
        if (flavor == 1) s.nz = 16'(16384 - $urandom_range(0, 400));
        else s.nz = 16'($urandom_range(0, 32768) - 16384);
        if ($urandom_range(0, 1)) s.nz = -s.nz;
        rest = QONE * QONE - longint'(s.nz) * longint'(s.nz);
        lim  = longint'(floor_sqrt(64'(rest)));
        s.nx = 16'(longint'($urandom_range(0, 2 * lim)) - lim);
        rest = rest - longint'(s.nx) * longint'(s.nx);
        s.ny = 16'(floor_sqrt(64'(rest)));
        if ($urandom_range(0, 1)) s.ny = -s.ny;
      end
    endcase
    return s;
  endfunction

  // --------------------------------------------------------- result checking
  always @(posedge clk) begin
    dir_t e;
    took <= 1'b0;
    if (!rst) cycles <= cycles + 1;
    if (out_valid && out_ready) begin
      took <= 1'b1;
      if (dir_queue.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected word %0d %0d %0d", dir_x, dir_y, dir_z);
      end else begin
        e = dir_queue.pop_front();
        if (e.x !== dir_x || e.y !== dir_y || e.z !== dir_z) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("dir mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                     e.x, e.y, e.z, dir_x, dir_y, dir_z);
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver stall, drawn per word
  always @(negedge clk) begin
    int wait_cycles;
    if (took) begin
      wait_cycles = quiet ? 0 : $urandom_range(0, 16);
      out_ready  <= (wait_cycles == 0);
      stall_left <= (wait_cycles == 0) ? 0 : wait_cycles - 1;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ------------------------------------------------------------------ stimulus
  stim_t table_rows[$];

  function automatic stim_t row(input int nx, input int ny, input int nz, input int ru,
                                input int rv, input int rw, input bit typed,
                                input int ex, input int ey, input int ez);
    stim_t s;
    s.nx = 16'(nx); s.ny = 16'(ny); s.nz = 16'(nz);
    s.ru = 16'(ru); s.rv = 16'(rv); s.rw = 16'(rw);
    s.typed = typed;
    s.want.x = chd_pkg::q14_t'(ex);
    s.want.y = chd_pkg::q14_t'(ey);
    s.want.z = chd_pkg::q14_t'(ez);
    return s;
  endfunction

  initial begin
    logic [14:0] phase_thr[5];
    threshold_model = 15'd1;
    // up pole and down pole, straight along the axis
    table_rows.push_back(row(0, 0, 16384, 32768, 0, 0, 1, 0, 0, 16384));
    table_rows.push_back(row(0, 0, -16384, 32768, 0, 0, 1, 0, 0, -16384));
    // a zero normal takes the rotated frame with zero scale: zero direction
    table_rows.push_back(row(0, 0, 0, 32768, 0, 0, 1, 0, 0, 0));
    // disk point outside the disk, and exactly at the center
    table_rows.push_back(row(0, 0, 16384, 0, 0, 100, 0, 0, 0, 0));
    table_rows.push_back(row(0, 0, 16384, 32768, 32768, 100, 0, 0, 0, 0));
    table_rows.push_back(row(0, 0, 16384, 65535, 65535, 65535, 0, 0, 0, 0));
    // disk rim points and extreme elevations
    table_rows.push_back(row(16384, 0, 0, 0, 32768, 0, 0, 0, 0, 0));
    table_rows.push_back(row(-16384, 0, 0, 65535, 32768, 65535, 0, 0, 0, 0));
    table_rows.push_back(row(0, 16384, 0, 32768, 65535, 32768, 0, 0, 0, 0));
    table_rows.push_back(row(0, -16384, 0, 32768, 1, 1, 0, 0, 0, 0));
    table_rows.push_back(row(11585, 0, 11585, 10000, 20000, 40000, 0, 0, 0, 0));
    table_rows.push_back(row(0, 11585, -11585, 50000, 40000, 12345, 0, 0, 0, 0));
    table_rows.push_back(row(16384, 16384, 16384, 1, 32768, 65535, 0, 0, 0, 0));
    table_rows.push_back(row(-16384, -16384, -16384, 65535, 32767, 0, 0, 0, 0, 0));
    table_rows.push_back(row(100, -50, 16383, 20000, 20000, 30000, 0, 0, 0, 0));
    table_rows.push_back(row(-100, 50, -16383, 40000, 30000, 30000, 0, 0, 0, 0));
    table_rows.push_back(row(5000, 9000, 12000, 32769, 32767, 65535, 0, 0, 0, 0));
    table_rows.push_back(row(-9000, 5000, -1, 9600, 56000, 100, 0, 0, 0, 0));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (table_rows[i]) send_word(table_rows[i]);
    drain();

    phase_thr[0] = 15'd0;
    phase_thr[1] = 15'd16384;
    phase_thr[2] = 15'd32767;
    phase_thr[3] = 15'($urandom_range(2, 1200));
    phase_thr[4] = 15'd1;
    foreach (phase_thr[p]) begin
      write_threshold(phase_thr[p]);
      for (int i = 0; i < 150; i++) begin
        if (i % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
        send_word(random_word($urandom_range(0, 5) == 0 ? 0 : $urandom_range(1, 2)));
      end
      drain();
    end

    if (mismatches == 0 && dir_queue.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
